>>> hw/rtl/lcd_line_timing_and_stat_interrupt_macros.svh
// assertion macros for the lcd line timing and status interrupt block
`ifndef LCD_LINE_TIMING_AND_STAT_INTERRUPT_MACROS_SVH
`define LCD_LINE_TIMING_AND_STAT_INTERRUPT_MACROS_SVH

`ifndef SYNTHESIS

`define LCDSTAT_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lcdstat assertion failed");

`define LCDSTAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcdstat assertion failed");

`else

`define LCDSTAT_ASSERT_ALWAYS(label, expr)

`define LCDSTAT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/lcdstat_pkg.sv
// types and constants shared by the lcd line timing and status interrupt block
`timescale 1ns / 1ps

package lcdstat_pkg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       vblank_irq;
        logic       stat_irq;
        logic       bad_address;
    } rsp_t;

    typedef struct packed {
        logic       enable;
        logic [7:0] status;
        logic [7:0] line;
        logic [7:0] compare;
        logic [6:0] dot;
        logic       stat_line;
    } tick_in_t;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] line;
        logic [6:0] dot;
        logic       stat_line;
        logic       vblank_irq;
        logic       stat_irq;
    } tick_out_t;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    localparam logic [6:0] DOTS_PER_LINE   = 7'd114;
    localparam logic [7:0] LINES_PER_FRAME = 8'd154;
    localparam logic [7:0] VISIBLE_LINES   = 8'd144;
    localparam logic [6:0] MODE3_START     = 7'd20;
    localparam logic [6:0] MODE0_START     = 7'(20 + 53);

    localparam logic [7:0] MODE_KEEP_MASK = 8'hFC;
    localparam logic [7:0] STATUS_FORCED  = 8'h80;

    localparam logic [15:0] ADDR_FIRST = 16'hFF40;
    localparam logic [15:0] ADDR_LAST  = 16'hFF4B;
    localparam logic [15:0] ADDR_LINE  = 16'hFF44;

    localparam logic [3:0] OFF_CONTROL = 4'd0;
    localparam logic [3:0] OFF_STATUS  = 4'd1;
    localparam logic [3:0] OFF_LINE    = 4'd4;
    localparam logic [3:0] OFF_COMPARE = 4'd5;

    localparam int CONTROL_ENABLE_BIT = 7;
    localparam int STAT_EN_HBLANK_BIT = 3;
    localparam int STAT_EN_VBLANK_BIT = 4;
    localparam int STAT_EN_OAM_BIT    = 5;
    localparam int STAT_EN_COINC_BIT  = 6;

endpackage

>>> hw/rtl/lcdstat_tick.sv
// dot and line counter step, mode sequencing and status condition for one tick
`timescale 1ns / 1ps

module lcdstat_tick (
    input  lcdstat_pkg::tick_in_t  tick_in,
    output lcdstat_pkg::tick_out_t tick_out
);
    import lcdstat_pkg::*;

    logic [6:0] dot_inc;
    logic       wrap;
    logic [6:0] dot_new;
    logic [7:0] line_new;
    logic       coinc;
    logic       visible;
    logic [1:0] mode;
    logic       vblank_enter;
    logic       cond;

    always_comb
    begin
        dot_inc  = tick_in.dot + 7'd1;
        wrap     = dot_inc >= DOTS_PER_LINE;
        dot_new  = wrap ? 7'd0 : dot_inc;
        if (wrap)
        begin
            line_new = (tick_in.line == LINES_PER_FRAME - 8'd1) ? 8'd0 : tick_in.line + 8'd1;
        end
        else
        begin
            line_new = tick_in.line;
        end
        coinc   = line_new == tick_in.compare;
        visible = line_new < VISIBLE_LINES;

        mode         = tick_in.status[1:0];
        vblank_enter = 1'b0;
        if (visible && dot_new >= MODE0_START)
        begin
            mode = MODE_HBLANK;
        end
        if (line_new == VISIBLE_LINES && dot_new == 7'd0)
        begin
            mode         = MODE_VBLANK;
            vblank_enter = 1'b1;
        end
        if (visible && dot_new == 7'd0)
        begin
            mode = MODE_OAM;
        end
        if (visible && dot_new == MODE3_START)
        begin
            mode = MODE_XFER;
        end

        cond = (coinc && tick_in.status[STAT_EN_COINC_BIT])
            || (mode == MODE_HBLANK && tick_in.status[STAT_EN_HBLANK_BIT])
            || (mode == MODE_VBLANK && tick_in.status[STAT_EN_VBLANK_BIT])
            || (mode == MODE_OAM && tick_in.status[STAT_EN_OAM_BIT]);

        if (tick_in.enable)
        begin
            tick_out.status     = {tick_in.status[7:3], coinc, mode};
            tick_out.line       = line_new;
            tick_out.dot        = dot_new;
            tick_out.stat_line  = cond;
            tick_out.vblank_irq = vblank_enter;
            tick_out.stat_irq   = cond && !tick_in.stat_line;
        end
        else
        begin
            // display off: clear mode, line and dot, keep the condition history
            tick_out.status     = tick_in.status & MODE_KEEP_MASK;
            tick_out.line       = 8'd0;
            tick_out.dot        = 7'd0;
            tick_out.stat_line  = tick_in.stat_line;
            tick_out.vblank_irq = 1'b0;
            tick_out.stat_irq   = 1'b0;
        end
    end

endmodule

>>> hw/rtl/lcd_line_timing_and_stat_interrupt.sv
// top level: register file, bus decode, tick sequencing and result register
// the result is registered at the edge that takes the transaction
// throughput: one transaction per cycle, set by the single result register
// a waiting result holds off the next transaction only while rsp_ready is low
// reset: rst_n clears the display registers, the counters and the result valid flag
// no clearing pass is needed after reset
`timescale 1ns / 1ps
`include "lcd_line_timing_and_stat_interrupt_macros.svh"

module lcd_line_timing_and_stat_interrupt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lcdstat_pkg::req_t   req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lcdstat_pkg::rsp_t   rsp
);
    import lcdstat_pkg::*;

    logic       accept;

    logic [7:0] control_reg, control_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] line_reg, line_next;
    logic [7:0] compare_reg, compare_next;
    logic [7:0] plain_reg [8];
    logic [7:0] plain_next [8];
    logic [6:0] dot_reg, dot_next;
    logic       stat_line_reg, stat_line_next;

    logic       rsp_valid_reg, rsp_valid_next;
    rsp_t       rsp_reg, rsp_next;

    logic [15:0] addr_diff;
    logic [3:0]  offset;
    logic        in_range;
    logic        plain_hit;
    logic [2:0]  plain_slot;
    logic [7:0]  read_mux;

    tick_in_t    tick_in;
    tick_out_t   tick_out;

    assign accept    = req_valid && req_ready;
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign tick_in.enable    = control_reg[CONTROL_ENABLE_BIT];
    assign tick_in.status    = status_reg;
    assign tick_in.line      = line_reg;
    assign tick_in.compare   = compare_reg;
    assign tick_in.dot       = dot_reg;
    assign tick_in.stat_line = stat_line_reg;

    lcdstat_tick u_tick (
        .tick_in  (tick_in),
        .tick_out (tick_out)
    );

    // address decode
    always_comb
    begin
        in_range  = req.bus_address >= ADDR_FIRST && req.bus_address <= ADDR_LAST;
        addr_diff = req.bus_address - ADDR_FIRST;
        offset    = addr_diff[3:0];
        case (offset) inside
            4'd2, 4'd3:
            begin
                plain_hit  = 1'b1;
                plain_slot = offset[2:0] - 3'd2;
            end
            [4'd6:4'd11]:
            begin
                plain_hit  = 1'b1;
                plain_slot = 3'(offset - 4'd4);
            end
            default:
            begin
                plain_hit  = 1'b0;
                plain_slot = 3'd0;
            end
        endcase

        case (offset)
            OFF_CONTROL: read_mux = control_reg;
            OFF_STATUS:  read_mux = status_reg;
            OFF_LINE:    read_mux = line_reg;
            OFF_COMPARE: read_mux = compare_reg;
            default:     read_mux = plain_hit ? plain_reg[plain_slot] : 8'd0;
        endcase
    end

    // next state and result
    always_comb
    begin
        control_next   = control_reg;
        status_next    = status_reg;
        line_next      = line_reg;
        compare_next   = compare_reg;
        plain_next     = plain_reg;
        dot_next       = dot_reg;
        stat_line_next = stat_line_reg;
        rsp_next       = '0;

        if (accept)
        begin
            case (req.opcode)
                OP_TICK:
                begin
                    status_next         = tick_out.status;
                    line_next           = tick_out.line;
                    dot_next            = tick_out.dot;
                    stat_line_next      = tick_out.stat_line;
                    rsp_next.vblank_irq = tick_out.vblank_irq;
                    rsp_next.stat_irq   = tick_out.stat_irq;
                end
                OP_READ:
                begin
                    if (!in_range)
                    begin
                        rsp_next.bad_address = 1'b1;
                    end
                    else
                    begin
                        rsp_next.read_data = read_mux;
                    end
                end
                OP_WRITE:
                begin
                    if (!in_range)
                    begin
                        rsp_next.bad_address = 1'b1;
                    end
                    else
                    begin
                        case (offset)
                            OFF_CONTROL: control_next = req.write_data;
                            OFF_STATUS:  status_next  = req.write_data | STATUS_FORCED;
                            OFF_LINE:    ;
                            OFF_COMPARE: compare_next = req.write_data;
                            default:
                            begin
                                if (plain_hit)
                                begin
                                    plain_next[plain_slot] = req.write_data;
                                end
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end

        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= 8'd0;
            status_reg    <= 8'd0;
            line_reg      <= 8'd0;
            compare_reg   <= 8'd0;
            for (int i = 0; i < 8; i++)
            begin
                plain_reg[i] <= 8'd0;
            end
            dot_reg       <= 7'd0;
            stat_line_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            control_reg   <= control_next;
            status_reg    <= status_next;
            line_reg      <= line_next;
            compare_reg   <= compare_next;
            plain_reg     <= plain_next;
            dot_reg       <= dot_next;
            stat_line_reg <= stat_line_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    `LCDSTAT_ASSERT_ALWAYS(a_counters_in_range,
        line_reg < LINES_PER_FRAME && dot_reg < DOTS_PER_LINE)

    `LCDSTAT_ASSERT_ALWAYS(a_vblank_mode,
        !(rsp_valid_reg && rsp_reg.vblank_irq)
        || (status_reg[1:0] == MODE_VBLANK && line_reg == VISIBLE_LINES && dot_reg == 7'd0))

    `LCDSTAT_ASSERT_ALWAYS(a_stat_irq_line,
        !(rsp_valid_reg && rsp_reg.stat_irq) || stat_line_reg)

    `LCDSTAT_ASSERT_NEXT(a_disabled_clears,
        accept && req.opcode == OP_TICK && !control_reg[CONTROL_ENABLE_BIT],
        line_reg == 8'd0 && dot_reg == 7'd0 && !rsp_reg.vblank_irq && !rsp_reg.stat_irq)

endmodule

>>> dv/lcd_line_timing_checker.sv
// checker for the lcd line timing block: watches both channels, predicts and compares responses
`timescale 1ns / 1ps

module lcd_line_timing_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  lcdstat_pkg::req_t   req,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  lcdstat_pkg::rsp_t   rsp,
    output int                  mismatch_count,
    output int                  pending_count,
    output int                  response_count,
    output int                  vblank_count,
    output int                  stat_irq_count
);
    import lcdstat_pkg::*;

    localparam int COINC_BIT = 2;
    localparam int REPORT_LIMIT = 10;

    logic [7:0] control_byte;
    logic [7:0] status_byte;
    logic [7:0] line_index;
    logic [7:0] line_match;
    logic [7:0] other_regs [0:11];
    logic [6:0] dot_index;
    logic       stat_level;

    rsp_t expected_responses [$];

    function automatic rsp_t predict_response(input req_t item);
        rsp_t       res;
        logic [3:0] off;
        logic [1:0] mode;
        logic       cond;
        res = '0;
        if (item.opcode == OP_TICK)
        begin
            if (!control_byte[CONTROL_ENABLE_BIT])
            begin
                status_byte = status_byte & MODE_KEEP_MASK;
                line_index = 8'd0;
                dot_index = 7'd0;
            end
            else
            begin
                dot_index = dot_index + 7'd1;
                if (dot_index >= DOTS_PER_LINE)
                begin
                    dot_index = 7'd0;
                    line_index = (line_index == LINES_PER_FRAME - 8'd1) ? 8'd0
                                                                        : line_index + 8'd1;
                end
                status_byte[COINC_BIT] = (line_index == line_match);
                if (line_index < VISIBLE_LINES && dot_index >= MODE0_START)
                    status_byte[1:0] = MODE_HBLANK;
                if (line_index == VISIBLE_LINES && dot_index == 7'd0)
                begin
                    status_byte[1:0] = MODE_VBLANK;
                    res.vblank_irq = 1'b1;
                end
                if (line_index < VISIBLE_LINES && dot_index == 7'd0)
                    status_byte[1:0] = MODE_OAM;
                if (line_index < VISIBLE_LINES && dot_index == MODE3_START)
                    status_byte[1:0] = MODE_XFER;
                mode = status_byte[1:0];
                cond = (status_byte[STAT_EN_COINC_BIT] && line_index == line_match) ||
                       (status_byte[STAT_EN_HBLANK_BIT] && mode == MODE_HBLANK) ||
                       (status_byte[STAT_EN_VBLANK_BIT] && mode == MODE_VBLANK) ||
                       (status_byte[STAT_EN_OAM_BIT] && mode == MODE_OAM);
                res.stat_irq = cond && !stat_level;
                stat_level = cond;
            end
        end
        else if (item.opcode == OP_READ || item.opcode == OP_WRITE)
        begin
            if (item.bus_address < ADDR_FIRST || item.bus_address > ADDR_LAST)
            begin
                res.bad_address = 1'b1;
            end
            else
            begin
                off = 4'(item.bus_address - ADDR_FIRST);
                if (item.opcode == OP_READ)
                begin
                    case (off)
                        OFF_CONTROL: res.read_data = control_byte;
                        OFF_STATUS:  res.read_data = status_byte;
                        OFF_LINE:    res.read_data = line_index;
                        OFF_COMPARE: res.read_data = line_match;
                        default:     res.read_data = other_regs[off];
                    endcase
                end
                else
                begin
                    case (off)
                        OFF_CONTROL: control_byte = item.write_data;
                        OFF_STATUS:  status_byte = item.write_data | STATUS_FORCED;
                        OFF_LINE:    ;
                        OFF_COMPARE: line_match = item.write_data;
                        default:     other_regs[off] = item.write_data;
                    endcase
                end
            end
        end
        return res;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch in %s of response %0d: expected 0x%0h, got 0x%0h",
                         field, response_count, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        rsp_t predicted;
        if (!rst_n)
        begin
            control_byte = '0;
            status_byte = '0;
            line_index = '0;
            line_match = '0;
            for (int i = 0; i < 12; i++)
                other_regs[i] = '0;
            dot_index = '0;
            stat_level = 1'b0;
            expected_responses.delete();
            mismatch_count = 0;
            pending_count = 0;
            response_count = 0;
            vblank_count = 0;
            stat_irq_count = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                response_count++;
                if (expected_responses.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("response %0d arrived with no transaction waiting",
                                 response_count);
                end
                else
                begin
                    want = expected_responses.pop_front();
                    check_field("read_data", want.read_data, rsp.read_data);
                    check_field("vblank_irq", want.vblank_irq, rsp.vblank_irq);
                    check_field("stat_irq", want.stat_irq, rsp.stat_irq);
                    check_field("bad_address", want.bad_address, rsp.bad_address);
                    if (want.vblank_irq)
                        vblank_count++;
                    if (want.stat_irq)
                        stat_irq_count++;
                end
            end
            if (req_valid && req_ready)
            begin
                predicted = predict_response(req);
                expected_responses = {expected_responses, predicted};
            end
            pending_count = expected_responses.size();
        end
    end

endmodule

>>> dv/lcd_line_timing_and_stat_interrupt_test.sv
// testbench top for the lcd line timing block: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps

module lcd_line_timing_and_stat_interrupt_test;
    import lcdstat_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int RESET_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 150;
    localparam int SWEEP_ITEMS = 320;
    localparam int SWEEP_SLICE = 80;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_pending = 1'b0;
    int   quiet_cycles = 0;

    int mismatches;
    int pending;
    int responses;
    int vblanks;
    int stat_irqs;

    lcd_line_timing_and_stat_interrupt u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    lcd_line_timing_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .mismatch_count (mismatches),
        .pending_count  (pending),
        .response_count (responses),
        .vblank_count   (vblanks),
        .stat_irq_count (stat_irqs)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("tb: no transaction for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver side, with one long hold-off on request
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_pending = 1'b0;
            end
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic set_idling(input int mix);
        case (mix)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 81;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 81;
            end
            default:
            begin
                send_idle_pct = 38;
                recv_stall_pct = 38;
            end
        endcase
    endtask

    task automatic send_item(input req_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic access(input logic [1:0] op, input logic [15:0] addr,
                          input logic [7:0] data);
        req_t item;
        item.opcode = op;
        item.bus_address = addr;
        item.write_data = data;
        send_item(item);
    endtask

    function automatic req_t random_access();
        req_t item;
        int   pick;
        item.write_data = 8'($urandom);
        item.bus_address = ADDR_FIRST + 16'($urandom_range(0, 11));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            item.opcode = OP_TICK;
        else if (pick < 70)
            item.opcode = OP_READ;
        else if (pick < 95)
            item.opcode = OP_WRITE;
        else
            item.opcode = OP_NONE;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            item.bus_address = 16'($urandom);
        else if (pick < 8)
            item.bus_address = ADDR_FIRST - 16'd1;
        else if (pick < 10)
            item.bus_address = ADDR_LAST + 16'd1;
        if (item.opcode == OP_WRITE && item.bus_address == ADDR_FIRST + 16'(OFF_CONTROL)
            && $urandom_range(0, 9) != 0)
            item.write_data[CONTROL_ENABLE_BIT] = 1'b1;
        if (item.opcode == OP_WRITE && item.bus_address == ADDR_FIRST + 16'(OFF_COMPARE)
            && $urandom_range(0, 3) != 0)
            item.write_data = 8'($urandom_range(0, 3));
        return item;
    endfunction

    // mostly ticks, so several lines pass, with register reads and status and compare writes mixed in
    function automatic req_t frame_item();
        req_t item;
        int   pick;
        item.opcode = OP_TICK;
        item.bus_address = 16'($urandom);
        item.write_data = 8'($urandom);
        pick = $urandom_range(0, 199);
        if (pick < 2)
        begin
            item.opcode = OP_READ;
            item.bus_address = ADDR_FIRST + 16'($urandom_range(0, 11));
        end
        else if (pick < 3)
        begin
            item.opcode = OP_WRITE;
            item.bus_address = ADDR_FIRST + 16'(OFF_STATUS);
        end
        else if (pick < 4)
        begin
            item.opcode = OP_WRITE;
            item.bus_address = ADDR_FIRST + 16'(OFF_COMPARE);
            item.write_data = 8'($urandom_range(0, 153));
        end
        return item;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed
        access(OP_READ,  ADDR_LINE, 8'h00);
        access(OP_TICK,  ADDR_FIRST, 8'h00);
        access(OP_WRITE, ADDR_FIRST + 16'(OFF_CONTROL), 8'hFF);
        access(OP_WRITE, ADDR_FIRST + 16'(OFF_STATUS), 8'h78);
        access(OP_READ,  ADDR_FIRST + 16'(OFF_STATUS), 8'h00);
        access(OP_WRITE, ADDR_LINE, 8'hAA);
        access(OP_READ,  ADDR_LINE, 8'h00);
        access(OP_TICK,  16'hFFFF, 8'hFF);
        access(OP_TICK,  16'h0000, 8'h00);
        access(OP_WRITE, ADDR_FIRST + 16'(OFF_COMPARE), 8'hFF);
        access(OP_TICK,  ADDR_LAST, 8'h00);
        access(OP_WRITE, ADDR_FIRST + 16'(OFF_STATUS), 8'h00);
        access(OP_READ,  ADDR_FIRST + 16'(OFF_STATUS), 8'h00);
        access(OP_WRITE, ADDR_FIRST + 16'd2, 8'hFF);
        access(OP_WRITE, ADDR_LAST, 8'h00);
        access(OP_READ,  ADDR_LAST, 8'h00);
        access(OP_READ,  ADDR_FIRST - 16'd1, 8'h00);
        access(OP_WRITE, ADDR_LAST + 16'd1, 8'hFF);
        access(OP_READ,  16'h0000, 8'h00);
        access(OP_WRITE, 16'hFFFF, 8'hFF);
        access(OP_NONE,  ADDR_FIRST, 8'hFF);
        access(OP_WRITE, ADDR_FIRST + 16'(OFF_CONTROL), 8'h00);
        access(OP_TICK,  ADDR_FIRST, 8'h00);
        access(OP_READ,  ADDR_FIRST + 16'(OFF_CONTROL), 8'h00);
        access(OP_READ,  ADDR_LINE, 8'h00);

        // random traffic under each idling mix, with a long receiver hold-off first
        for (int mix = 0; mix < 4; mix++)
        begin
            set_idling(mix);
            if (mix == 0)
                hold_pending = 1'b1;
            repeat (RANDOM_ITEMS) send_item(random_access());
        end

        // a run of ticks across several lines, from line 0
        access(OP_WRITE, ADDR_FIRST + 16'(OFF_CONTROL), 8'h00);
        access(OP_TICK, ADDR_FIRST, 8'h00);
        access(OP_WRITE, ADDR_FIRST + 16'(OFF_STATUS), 8'($urandom));
        access(OP_WRITE, ADDR_FIRST + 16'(OFF_COMPARE), 8'($urandom_range(0, 3)));
        access(OP_WRITE, ADDR_FIRST + 16'(OFF_CONTROL), 8'($urandom) | 8'h80);
        for (int i = 0; i < SWEEP_ITEMS; i++)
        begin
            if (i % SWEEP_SLICE == 0)
                set_idling((i / SWEEP_SLICE) % 4);
            send_item(frame_item());
        end

        req_valid <= 1'b0;
        set_idling(0);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb: %0d responses checked across directed, random and long tick traffic",
                 responses);
        $display("tb: vblank entered %0d times, status interrupt raised %0d times",
                 vblanks, stat_irqs);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
